### rtl/core/gbi_pkg.sv
// gbi_pkg: shared constants and types for the grid bilinear interpolator
// no dependencies
`default_nettype none
package gbi_pkg;
   localparam int GRID_DEPTH  = 4096;
   localparam int GRID_ADDR_W = $clog2(GRID_DEPTH);
   localparam int COUNT_W     = 13;
   localparam int SAMPLE_IDX_W = 12;
   localparam int CSR_IDX_W   = 3;
   // flat address arithmetic before the depth check: 8191*8191 plus a row and a column
   localparam int FLAT_W      = 26;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIAL_ORIGIN = 3'd0,
      CSR_RADIAL_RECIP  = 3'd1,
      CSR_AXIAL_RECIP   = 3'd2,
      CSR_RADIAL_COUNT  = 3'd3,
      CSR_AXIAL_COUNT   = 3'd4
   } csr_idx_type;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
endpackage
`default_nettype wire

### rtl/core/grid_bilinear_interpolator.sv
// grid_bilinear_interpolator: bilinear lookup over a radial-by-axial sample grid
// a query result is registered through every pipeline stage and the output register; writes give none
// throughput: one transaction per cycle, busy never rises; two mirrored dual-read rams
// give the four neighbor reads in the same cycle; the receiver cannot stall
// reset: synchronous, clears valids and loads register defaults; grid undefined until written
// depends on gbi_pkg and gbi_ram
`default_nettype none
module grid_bilinear_interpolator (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_command,
   input  wire  [gbi_pkg::SAMPLE_IDX_W-1:0]    req_sample_index,
   input  wire  signed [31:0]                  req_sample_value,
   input  wire  signed [31:0]                  req_query_radius,
   input  wire  signed [31:0]                  req_query_height,
   // result channel
   output logic                                rsp_valid,
   output logic signed [31:0]                  rsp_value,
   output logic                                rsp_in_range,
   // register write channel
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [gbi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [31:0]                         csr_data
);
   import gbi_pkg::*;

   // configuration registers
   logic signed [31:0]  radial_origin_ff;
   logic [31:0]         radial_recip_ff;
   logic [31:0]         axial_recip_ff;
   logic [COUNT_W-1:0]  radial_count_ff;
   logic [COUNT_W-1:0]  axial_count_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radial_origin_ff <= '0;
         radial_recip_ff  <= 32'd655360;
         axial_recip_ff   <= 32'd65536;
         radial_count_ff  <= 13'd64;
         axial_count_ff   <= 13'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_RADIAL_ORIGIN: radial_origin_ff <= csr_data;
            CSR_RADIAL_RECIP:  radial_recip_ff  <= csr_data;
            CSR_AXIAL_RECIP:   axial_recip_ff   <= csr_data;
            CSR_RADIAL_COUNT:  radial_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_AXIAL_COUNT:   axial_count_ff   <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   wire accept = start && !busy;

   // stage 1: offset and magnitude; writes ride along so they hit the ram in order
   logic               s1_vld_ff, s1_qry_ff;
   logic [SAMPLE_IDX_W-1:0] s1_widx_ff;
   logic [31:0]        s1_wdat_ff;
   logic signed [32:0] s1_diff_ff;
   logic [31:0]        s1_az_ff;
   logic signed [32:0] s1_diff_in;
   logic [32:0]        s1_az_wide;

   assign s1_diff_in = 33'(req_query_radius) - 33'(radial_origin_ff);
   assign s1_az_wide = req_query_height[31] ? (33'd0 - 33'(req_query_height))
                                            : 33'(req_query_height);

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= accept;
      s1_qry_ff  <= req_command == CMD_QUERY;
      s1_widx_ff <= req_sample_index;
      s1_wdat_ff <= req_sample_value;
      s1_diff_ff <= s1_diff_in;
      s1_az_ff   <= s1_az_wide[31:0];
   end

   // stage 2: scale by reciprocal steps
   logic        s2_vld_ff, s2_qry_ff, s2_neg_ff;
   logic [SAMPLE_IDX_W-1:0] s2_widx_ff;
   logic [31:0] s2_wdat_ff;
   logic [63:0] s2_rr_ff, s2_zz_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
      s2_qry_ff  <= s1_qry_ff;
      s2_widx_ff <= s1_widx_ff;
      s2_wdat_ff <= s1_wdat_ff;
      s2_neg_ff  <= s1_diff_ff[32];
      s2_rr_ff   <= 64'(s1_diff_ff[31:0]) * 64'(radial_recip_ff);
      s2_zz_ff   <= 64'(s1_az_ff) * 64'(axial_recip_ff);
   end

   // stage 3: index range checks and base address
   logic        s3_vld_ff, s3_qry_ff, s3_inr_ff, s3_hasr_ff, s3_hasz_ff;
   logic [SAMPLE_IDX_W-1:0] s3_widx_ff;
   logic [31:0] s3_wdat_ff;
   logic [15:0] s3_dr_ff, s3_dz_ff;
   logic [FLAT_W-1:0] s3_base_ff;
   logic [31:0] ir, iz;
   logic        inr;

   assign ir  = s2_rr_ff[63:32];
   assign iz  = s2_zz_ff[63:32];
   assign inr = !s2_neg_ff && (ir < 32'(radial_count_ff)) && (iz < 32'(axial_count_ff));

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
      s3_qry_ff  <= s2_qry_ff;
      s3_widx_ff <= s2_widx_ff;
      s3_wdat_ff <= s2_wdat_ff;
      s3_inr_ff  <= inr;
      s3_hasr_ff <= (33'(ir) + 33'd1) < 33'(radial_count_ff);
      s3_hasz_ff <= (33'(iz) + 33'd1) < 33'(axial_count_ff);
      s3_dr_ff   <= s2_rr_ff[31:16];
      s3_dz_ff   <= s2_zz_ff[31:16];
      s3_base_ff <= FLAT_W'(ir[12:0]) * FLAT_W'(axial_count_ff) + FLAT_W'(iz[12:0]);
   end

   // stage 3 also drives the rams: neighbor reads, or the sample write
   logic [FLAT_W-1:0] a00, a10, a01, a11;
   logic              ok00, ok10, ok01, ok11, wr_en;
   logic [31:0]       q00, q10, q01, q11;

   assign a00  = s3_base_ff;
   assign a10  = s3_base_ff + FLAT_W'(axial_count_ff);
   assign a01  = s3_base_ff + FLAT_W'(1);
   assign a11  = a10 + FLAT_W'(1);
   assign ok00 = a00 < FLAT_W'(GRID_DEPTH);
   assign ok10 = s3_hasr_ff && (a10 < FLAT_W'(GRID_DEPTH));
   assign ok01 = s3_hasz_ff && (a01 < FLAT_W'(GRID_DEPTH));
   assign ok11 = s3_hasr_ff && s3_hasz_ff && (a11 < FLAT_W'(GRID_DEPTH));
   assign wr_en = s3_vld_ff && !s3_qry_ff && (FLAT_W'(s3_widx_ff) < FLAT_W'(GRID_DEPTH));

   gbi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_ram_row (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (GRID_ADDR_W'(s3_widx_ff)),
      .wr_data   (s3_wdat_ff),
      .rd_addr_a (a00[GRID_ADDR_W-1:0]),
      .rd_addr_b (a10[GRID_ADDR_W-1:0]),
      .rd_data_a (q00),
      .rd_data_b (q10)
   );

   gbi_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_ram_col (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (GRID_ADDR_W'(s3_widx_ff)),
      .wr_data   (s3_wdat_ff),
      .rd_addr_a (a01[GRID_ADDR_W-1:0]),
      .rd_addr_b (a11[GRID_ADDR_W-1:0]),
      .rd_data_a (q01),
      .rd_data_b (q11)
   );

   // stage 4: ram data back, only queries continue
   logic        s4_vld_ff, s4_inr_ff;
   logic [3:0]  s4_ok_ff;
   logic [15:0] s4_dr_ff, s4_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else       s4_vld_ff <= s3_vld_ff && s3_qry_ff;
      s4_inr_ff <= s3_inr_ff;
      s4_ok_ff  <= {ok11, ok01, ok10, ok00};
      s4_dr_ff  <= s3_dr_ff;
      s4_dz_ff  <= s3_dz_ff;
   end

   // missing neighbors read as zero
   logic signed [31:0] f00, f10, f01, f11;
   logic signed [17:0] wr0, wr1;
   assign f00 = s4_ok_ff[0] ? q00 : '0;
   assign f10 = s4_ok_ff[1] ? q10 : '0;
   assign f01 = s4_ok_ff[2] ? q01 : '0;
   assign f11 = s4_ok_ff[3] ? q11 : '0;
   assign wr0 = 18'sd65536 - $signed({2'b00, s4_dr_ff});
   assign wr1 = $signed({2'b00, s4_dr_ff});

   // stage 5: radial blends of both axial rows
   logic               s5_vld_ff, s5_inr_ff;
   logic [15:0]        s5_dz_ff;
   logic signed [48:0] s5_row0_ff, s5_row1_ff;
   logic signed [49:0] p00, p10, p01, p11;
   logic signed [49:0] row0_sum, row1_sum;

   assign p00 = wr0 * f00;
   assign p10 = wr1 * f10;
   assign p01 = wr0 * f01;
   assign p11 = wr1 * f11;
   assign row0_sum = p00 + p10;
   assign row1_sum = p01 + p11;

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else       s5_vld_ff <= s4_vld_ff;
      s5_inr_ff  <= s4_inr_ff;
      s5_dz_ff   <= s4_dz_ff;
      s5_row0_ff <= row0_sum[48:0];
      s5_row1_ff <= row1_sum[48:0];
   end

   // stage 6: axial blend
   logic               s6_vld_ff, s6_inr_ff;
   logic signed [63:0] s6_acc_ff;
   logic signed [17:0] wz0, wz1;
   logic signed [66:0] pa, pb, acc_sum;

   assign wz0 = 18'sd65536 - $signed({2'b00, s5_dz_ff});
   assign wz1 = $signed({2'b00, s5_dz_ff});
   assign pa  = wz0 * s5_row0_ff;
   assign pb  = wz1 * s5_row1_ff;
   assign acc_sum = pa + pb;

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else       s6_vld_ff <= s5_vld_ff;
      s6_inr_ff <= s5_inr_ff;
      s6_acc_ff <= acc_sum[63:0];
   end

   // output: round half up; the blend bounds keep the result inside 32 bits
   logic        rsp_valid_ff, rsp_inr_ff;
   logic [31:0] rsp_value_ff;
   logic [63:0] rounded;

   assign rounded = s6_acc_ff + 64'h0000_0000_8000_0000;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s6_vld_ff;
      rsp_inr_ff   <= s6_inr_ff;
      rsp_value_ff <= s6_inr_ff ? rounded[63:32] : '0;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_in_range = rsp_inr_ff;

   // a query that reaches the last stage is always answered next cycle
   a_answer: assert property (@(posedge clock) disable iff (reset)
      s6_vld_ff |=> rsp_valid)
      else $error("query lost in output stage");

   // out of range answers carry zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |-> (rsp_value == 32'd0))
      else $error("out of range result not zero");

   // a write in the ram stage never becomes a valid blend stage entry
   a_nowrite: assert property (@(posedge clock) disable iff (reset)
      (s3_vld_ff && !s3_qry_ff) |=> !s4_vld_ff)
      else $error("write leaked into query pipeline");

   // results are only produced by accepted queries
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s6_vld_ff))
      else $error("result without query");
endmodule
`default_nettype wire

### rtl/core/gbi_ram.sv
// gbi_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none
module gbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule
`default_nettype wire

### sim/testbench.sv
// testbench for grid_bilinear_interpolator: directed and random grid writes and queries,
// results checked against an in-bench bilinear predictor
// depends on gbi_pkg and the grid_bilinear_interpolator rtl
`default_nettype none
module testbench;
   import gbi_pkg::*;

   // register index that no register answers to
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd6;

   typedef struct packed {
      logic signed [31:0] value;
      logic               in_range;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_command = CMD_WRITE;
   logic [SAMPLE_IDX_W-1:0] req_sample_index = '0;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_query_radius = '0;
   logic signed [31:0] req_query_height = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_value;
   logic rsp_in_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   grid_bilinear_interpolator uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_command(req_command), .req_sample_index(req_sample_index),
      .req_sample_value(req_sample_value), .req_query_radius(req_query_radius),
      .req_query_height(req_query_height),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_in_range(rsp_in_range),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // shadow of the grid and the registers
   logic [31:0] grid_shadow [GRID_DEPTH];
   logic signed [31:0] origin_q;
   logic [31:0] radial_recip_q;
   logic [31:0] axial_recip_q;
   logic [COUNT_W-1:0] radial_count_q;
   logic [COUNT_W-1:0] axial_count_q;

   lookup_result_type pending_lookups[$];
   bit failed = 1'b0;
   int sender_idle_pct = 0;

   // samples past the grid depth read as zero
   function automatic longint sample_at(input logic [63:0] addr);
      if (addr >= GRID_DEPTH) return 0;
      return longint'($signed(grid_shadow[addr[GRID_ADDR_W-1:0]]));
   endfunction

   function automatic lookup_result_type interpolate(input logic signed [31:0] radius,
                                                     input logic signed [31:0] height);
      lookup_result_type res;
      longint diff, dr, dz, f00, f10, f01, f11, row0, row1, acc, v;
      logic [63:0] rr, zz, az, ir, iz, ac, base, u;
      bit has_r, has_z;
      res = '0;
      diff = longint'(radius) - longint'(origin_q);
      // below the origin
      if (diff < 0) return res;
      rr = 64'(diff) * {32'd0, radial_recip_q};
      ir = rr >> 32;
      if (ir >= {51'd0, radial_count_q}) return res;
      dr = longint'({48'd0, rr[31:16]});
      az = (height < 0) ? 64'(-longint'(height)) : 64'(longint'(height));
      zz = az * {32'd0, axial_recip_q};
      iz = zz >> 32;
      ac = {51'd0, axial_count_q};
      if (iz >= ac) return res;
      dz = longint'({48'd0, zz[31:16]});
      base = ir * ac + iz;
      has_r = (ir + 1) < {51'd0, radial_count_q};
      has_z = (iz + 1) < ac;
      // missing neighbors count as zero, corner too when either side is missing
      f00 = sample_at(base);
      f10 = has_r ? sample_at(base + ac) : 0;
      f01 = has_z ? sample_at(base + 1) : 0;
      f11 = (has_r && has_z) ? sample_at(base + ac + 1) : 0;
      row0 = (65536 - dr) * f00 + dr * f10;
      row1 = (65536 - dr) * f01 + dr * f11;
      acc = (65536 - dz) * row0 + dz * row1;
      // round half up through offset binary, then saturate
      u = 64'(acc) + 64'h8000_0000_8000_0000;
      v = longint'({32'd0, u[63:32]}) - 64'sh8000_0000;
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) v = -64'sh8000_0000;
      res.value = v[31:0];
      res.in_range = 1'b1;
      return res;
   endfunction

   // one request transaction, entered and left at a falling edge
   task automatic send_item(input logic cmd, input logic [SAMPLE_IDX_W-1:0] idx,
                            input logic [31:0] val, input logic [31:0] radius,
                            input logic [31:0] height);
      req_command = cmd;
      req_sample_index = idx;
      req_sample_value = val;
      req_query_radius = radius;
      req_query_height = height;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd == CMD_WRITE) grid_shadow[idx] = val;
      else pending_lookups.push_back(interpolate(radius, height));
      @(negedge clock);
      // sender gap: each cycle idles with the set chance, start drops here and in quiesce
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   // drain everything in flight; writes give no result, so also wait out the latency
   task automatic quiesce();
      start = 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RADIAL_ORIGIN: origin_q = data;
         CSR_RADIAL_RECIP:  radial_recip_q = data;
         CSR_AXIAL_RECIP:   axial_recip_q = data;
         CSR_RADIAL_COUNT:  radial_count_q = data[COUNT_W-1:0];
         CSR_AXIAL_COUNT:   axial_count_q = data[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_setting(input logic [31:0] org, input logic [31:0] rrec,
                                input logic [31:0] arec, input logic [31:0] rc,
                                input logic [31:0] acnt);
      quiesce();
      csr_write(CSR_RADIAL_ORIGIN, org);
      csr_write(CSR_RADIAL_RECIP, rrec);
      csr_write(CSR_AXIAL_RECIP, arec);
      csr_write(CSR_RADIAL_COUNT, rc);
      csr_write(CSR_AXIAL_COUNT, acnt);
   endtask

   // queries only ever read the low and the high end of the grid, so those get values
   task automatic test_grid_fill();
      sender_idle_pct = 11;
      for (int i = 0; i < 256; i++)
         send_item(CMD_WRITE, SAMPLE_IDX_W'(i), $urandom, $urandom, $urandom);
      for (int i = GRID_DEPTH - 256; i < GRID_DEPTH; i++)
         send_item(CMD_WRITE, SAMPLE_IDX_W'(i), $urandom, $urandom, $urandom);
   endtask

   task automatic test_reset_defaults();
      // reset registers: step 0.1 radially, one axial sample per row
      send_item(CMD_QUERY, '0, $urandom, 32'h0001_8000, 32'h0000_4000);
      send_item(CMD_QUERY, '0, $urandom, 32'h0006_4000, 32'hFFFF_C000);
   endtask

   task automatic test_directed_cases();
      quiesce();
      sender_idle_pct = 0;
      // unmapped register index must leave everything alone
      csr_write(CSR_UNMAPPED, 32'hFFFF_FFFF);
      apply_setting(32'hFFFE_0000, 32'h0001_0000, 32'h0002_0000, 4, 3);
      // extreme samples on a 4x3 grid
      send_item(CMD_WRITE, 12'd0, 32'h7FFF_FFFF, '0, '0);
      send_item(CMD_WRITE, 12'd1, 32'h8000_0000, '0, '0);
      send_item(CMD_WRITE, 12'd3, 32'h7FFF_FFFF, '0, '0);
      send_item(CMD_WRITE, 12'd4, 32'h7FFF_FFFF, '0, '0);
      send_item(CMD_WRITE, 12'd8, 32'h8000_0000, '0, '0);
      send_item(CMD_WRITE, 12'd11, 32'h0100_0000, '0, '0);
      send_item(CMD_QUERY, '0, '0, 32'hFFFD_0000, '0);           // below the origin
      send_item(CMD_QUERY, '0, '0, 32'hFFFE_8000, 32'h0000_2000); // blend of extreme samples
      send_item(CMD_QUERY, '0, '0, 32'h0001_8000, 32'h0000_4000); // last row
      send_item(CMD_QUERY, '0, '0, 32'hFFFF_4000, 32'h0001_4000); // last column
      send_item(CMD_QUERY, '0, '0, 32'h0001_C000, 32'h0001_6000); // missing corner
      send_item(CMD_QUERY, '0, '0, 32'h0002_0000, '0);           // past the rows
      send_item(CMD_QUERY, '0, '0, '0, 32'h0001_8000);           // past the columns
      send_item(CMD_QUERY, '0, '0, '0, 32'hFFFF_4000);           // negative height
      send_item(CMD_QUERY, '0, '0, 32'h7FFF_FFFF, '0);
      send_item(CMD_QUERY, '0, '0, 32'h8000_0000, 32'h8000_0000);
      send_item(CMD_QUERY, '0, '0, 32'hFFFE_0000, 32'h8000_0000);
      // zero counts: nothing is in range
      apply_setting(0, 32'h0001_0000, 32'h0001_0000, 0, 0);
      send_item(CMD_QUERY, '0, '0, 32'h0000_8000, '0);
      send_item(CMD_QUERY, '0, '0, '0, '0);
   endtask

   // query aimed inside the configured grid, with random content
   task automatic send_aimed_query();
      logic [63:0] span_r, span_z, off, hgt;
      logic [31:0] height;
      span_r = {19'd0, radial_count_q, 32'd0} / {32'd0, radial_recip_q};
      span_z = {19'd0, axial_count_q, 32'd0} / {32'd0, axial_recip_q};
      off = {$urandom, $urandom} % (span_r + 1);
      hgt = {$urandom, $urandom} % (span_z + 1);
      if (hgt > 64'h7FFF_FFFF) hgt = {33'd0, 31'($urandom)};
      height = $urandom_range(1) ? -hgt[31:0] : hgt[31:0];
      send_item(CMD_QUERY, SAMPLE_IDX_W'($urandom), $urandom, origin_q + off[31:0], height);
   endtask

   task automatic run_random_items(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 25)
            send_item(CMD_WRITE, SAMPLE_IDX_W'($urandom), $urandom, $urandom, $urandom);
         else if (pick < 85)
            send_aimed_query();
         else
            send_item(CMD_QUERY, SAMPLE_IDX_W'($urandom), $urandom, $urandom, $urandom);
      end
   endtask

   // unit steps, origin zero: any row index, axial index kept below 255
   task automatic run_far_items(input int count);
      logic [31:0] radius, height;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 25) begin
            send_item(CMD_WRITE, SAMPLE_IDX_W'($urandom), $urandom, $urandom, $urandom);
         end else begin
            radius = $urandom % 32'h2000_0000;
            height = $urandom % 32'h00FF_0000;
            if ($urandom_range(1)) height = -height;
            send_item(CMD_QUERY, SAMPLE_IDX_W'($urandom), $urandom, radius, height);
         end
      end
   endtask

   task automatic test_random_phases();
      // sender idles often
      sender_idle_pct = 11;
      apply_setting(0, 32'h0001_0000, 32'h0001_0000, 16, 16);
      run_random_items(153);
      apply_setting(32'h8000_0000, 32'hFFFF_FFFF, 1, 256, 1);
      run_random_items(153);
      // heavier sender gaps
      sender_idle_pct = 48;
      apply_setting(32'h7FFF_0000, 1, 32'hFFFF_FFFF, 1, 256);
      run_random_items(153);
      apply_setting($urandom, $urandom_range(32'h0010_0000, 32'h0000_0100),
                    $urandom_range(32'h0010_0000, 32'h0000_0100), 8, 32);
      run_random_items(153);
      // back to back transactions
      sender_idle_pct = 0;
      apply_setting($urandom, 32'h0001_8000, 32'h0000_9C40, 10, 25);
      run_random_items(153);
      // counts beyond the grid depth read zeros past the end
      apply_setting(0, 32'h0001_0000, 32'h0001_0000, 8191, 4000);
      run_far_items(153);
   endtask

   // result checker: every strobe must match the oldest pending lookup
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $display("%0t: unexpected result value %h in_range %b", $time, rsp_value,
                     rsp_in_range);
            failed = 1'b1;
         end else begin
            exp_r = pending_lookups.pop_front();
            if (rsp_value !== exp_r.value) begin
               $display("%0t: value expected %h actual %h", $time, exp_r.value, rsp_value);
               failed = 1'b1;
            end
            if (rsp_in_range !== exp_r.in_range) begin
               $display("%0t: in_range expected %b actual %b", $time, exp_r.in_range,
                        rsp_in_range);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      origin_q = 0;
      radial_recip_q = 32'd655360;
      axial_recip_q = 32'd65536;
      radial_count_q = 13'd64;
      axial_count_q = 13'd1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_grid_fill();
      test_reset_defaults();
      test_directed_cases();
      test_random_phases();
      quiesce();
      repeat (20) @(negedge clock);
      if (!failed && pending_lookups.size() == 0) begin
         $display("grid_bilinear_interpolator verification clean");
      end else begin
         if (pending_lookups.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_lookups.size());
         $display("grid_bilinear_interpolator verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("grid_bilinear_interpolator verification failed");
      $finish;
   end
endmodule
`default_nettype wire
